// ===== design/space_packet_deframer_core_defines.svh =====
// Assertion macros used by the space packet deframer core.
`ifndef SPACE_PACKET_DEFRAMER_CORE_DEFINES_SVH
`define SPACE_PACKET_DEFRAMER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

`define SPD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define SPD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SPD_ASSERT(lbl, prop, msg)

`define SPD_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== design/spd_pkg.sv =====
// Types and constants of the space packet deframer.
package spd_pkg;

    localparam logic [2:0] EV_NONE   = 3'd0;
    localparam logic [2:0] EV_SYNC   = 3'd1;
    localparam logic [2:0] EV_ACCEPT = 3'd2;
    localparam logic [2:0] EV_REJECT = 3'd3;
    localparam logic [2:0] EV_END    = 3'd4;

    localparam logic [1:0] CLASS_NONE      = 2'd0;
    localparam logic [1:0] CLASS_ROUTINE   = 2'd1;
    localparam logic [1:0] CLASS_EMERGENCY = 2'd2;
    localparam logic [1:0] CLASS_UNKNOWN   = 2'd3;

    localparam logic [10:0] APID_IDLE      = 11'h7FF;
    localparam logic [7:0]  TYPE_EMERGENCY = 8'd8;
    localparam logic [7:0]  TYPE_ROUTINE_MAX = 8'd7;

    typedef struct packed {
        logic [10:0] apid;
        logic [1:0]  seg_flags;
        logic [13:0] seq_count;
        logic [16:0] data_length;
        logic        sec_header;
        logic        reject;
    } hdr_fields_t;

endpackage

// ===== design/spd_hdr_decode.sv =====
// Decoder of the six-byte primary header into its fields and the reject check.
module spd_hdr_decode (
    input  logic [47:0]              header,
    output spd_pkg::hdr_fields_t     fields
);
    import spd_pkg::*;

    logic [15:0] w1;
    logic [15:0] w2;
    logic [15:0] w3;
    logic [2:0]  version;
    logic        type_bit;

    assign w1 = header[47:32];
    assign w2 = header[31:16];
    assign w3 = header[15:0];
    assign version  = w1[15:13];
    assign type_bit = w1[12];

    always_comb
    begin
        fields.apid        = w1[10:0];
        fields.seg_flags   = w2[15:14];
        fields.seq_count   = w2[13:0];
        fields.data_length = {1'b0, w3} + 17'd1;
        fields.sec_header  = w1[11];
        fields.reject      = (version != 3'd0) || type_bit ||
                             ((w1[10:0] == APID_IDLE) && w1[11]);
    end

endmodule

// ===== design/space_packet_deframer_core.sv =====
// Top level of the space packet deframer: byte input, one event request per byte out.
//
// The s_ channel takes one received byte per request in s_tdata. For every byte the
// block returns exactly one request on the m_ channel: m_tuser carries the event code
// (none, sync found, header accepted, header rejected, packet ended) and m_tdata the
// header fields and the secondary-header classification that go with it.
// The block hunts for the sync marker over the last four bytes, captures the next six
// bytes as the primary header and then counts off the data field.
// The state update and the result for a byte are formed by logic between the state
// registers and the output register, so the event for a byte appears on the m_ channel
// in the cycle after the byte is taken. One byte is taken per clock as long as the
// output register is empty or being emptied. When the receiver stalls, the output
// register holds its request and s_tready drops until that request is taken. The sync
// marker is written through cfg_wr_en and cfg_wr_data; the user must write it only while
// the block is idle, since the block itself does not enforce this.
// Reset clears the window, returns to hunting, empties the output register and loads
// the sync marker with its default value.
`include "space_packet_deframer_core_defines.svh"

module space_packet_deframer_core #(
    parameter logic [31:0] SYNC_MARKER_RESET = 32'h1ACFFC1D
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [10:0] apid, [12:11] seg_flags, [26:13] seq_count,
                                   // [43:27] data_length, [44] sec_header,
                                   // [52:45] telemetry_type, [54:53] type_class, [55] zero
    output logic [2:0]  m_tuser    // [2:0] event_res
);
    import spd_pkg::*;

    localparam logic [1:0] PH_HUNT   = 2'd0;
    localparam logic [1:0] PH_HEADER = 2'd1;
    localparam logic [1:0] PH_DATA   = 2'd2;

    logic [31:0] sync_marker_reg;
    logic [31:0] sync_window_reg, sync_window_next;
    logic [2:0]  window_fill_reg, window_fill_next;
    logic [1:0]  phase_reg, phase_next;
    logic [2:0]  header_index_reg, header_index_next;
    logic [47:0] header_store_reg, header_store_next;
    logic [16:0] data_index_reg, data_index_next;
    logic [7:0]  first_byte_reg, first_byte_next;

    logic        out_valid_reg;
    logic [55:0] out_data_reg, out_data_next;
    logic [2:0]  out_event_reg, out_event_next;

    logic        in_accept;
    hdr_fields_t hdr;
    logic [7:0]  b;
    logic [1:0]  type_class;
    logic [7:0]  telemetry_type;
    logic        report_header;

    assign b         = s_tdata;
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;

    spd_hdr_decode u_hdr_decode (
        .header (header_store_next),
        .fields (hdr)
    );

    always_comb
    begin
        sync_window_next  = sync_window_reg;
        window_fill_next  = window_fill_reg;
        phase_next        = phase_reg;
        header_index_next = header_index_reg;
        header_store_next = header_store_reg;
        data_index_next   = data_index_reg;
        first_byte_next   = first_byte_reg;
        out_event_next    = EV_NONE;
        report_header     = 1'b0;

        if (phase_reg == PH_DATA)
        begin
            if (data_index_reg == 17'd0)
            begin
                first_byte_next = b;
            end
            if (data_index_reg >= {1'b0, header_store_reg[15:0]})
            begin
                out_event_next  = EV_END;
                report_header   = 1'b1;
                phase_next      = PH_HUNT;
                data_index_next = 17'd0;
            end
            else
            begin
                data_index_next = data_index_reg + 17'd1;
            end
        end
        else
        begin
            sync_window_next = {sync_window_reg[23:0], b};
            if (window_fill_reg < 3'd4)
            begin
                window_fill_next = window_fill_reg + 3'd1;
            end
            if (phase_reg == PH_HEADER)
            begin
                header_store_next = {header_store_reg[39:0], b};
                if (header_index_reg >= 3'd5)
                begin
                    header_index_next = 3'd0;
                    report_header     = 1'b1;
                    if (hdr.reject)
                    begin
                        out_event_next = EV_REJECT;
                        phase_next     = PH_HUNT;
                    end
                    else
                    begin
                        out_event_next  = EV_ACCEPT;
                        phase_next      = PH_DATA;
                        data_index_next = 17'd0;
                    end
                end
                else
                begin
                    header_index_next = header_index_reg + 3'd1;
                end
            end
            else
            begin
                phase_next = PH_HUNT;
                if ((window_fill_next >= 3'd4) && (sync_window_next == sync_marker_reg))
                begin
                    out_event_next    = EV_SYNC;
                    phase_next        = PH_HEADER;
                    header_index_next = 3'd0;
                end
            end
        end
    end

    always_comb
    begin
        telemetry_type = 8'd0;
        type_class     = CLASS_NONE;
        if ((out_event_next == EV_END) && hdr.sec_header)
        begin
            telemetry_type = first_byte_next;
            priority if ((first_byte_next >= 8'd1) && (first_byte_next <= TYPE_ROUTINE_MAX))
            begin
                type_class = CLASS_ROUTINE;
            end
            else if (first_byte_next == TYPE_EMERGENCY)
            begin
                type_class = CLASS_EMERGENCY;
            end
            else
            begin
                type_class = CLASS_UNKNOWN;
            end
        end
    end

    always_comb
    begin
        out_data_next = 56'd0;
        if (report_header)
        begin
            out_data_next[10:0]  = hdr.apid;
            out_data_next[12:11] = hdr.seg_flags;
            out_data_next[26:13] = hdr.seq_count;
            out_data_next[43:27] = hdr.data_length;
            out_data_next[44]    = hdr.sec_header;
        end
        out_data_next[52:45] = telemetry_type;
        out_data_next[54:53] = type_class;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_marker_reg  <= SYNC_MARKER_RESET;
            sync_window_reg  <= 32'd0;
            window_fill_reg  <= 3'd0;
            phase_reg        <= PH_HUNT;
            header_index_reg <= 3'd0;
            header_store_reg <= 48'd0;
            data_index_reg   <= 17'd0;
            first_byte_reg   <= 8'd0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                sync_marker_reg <= cfg_wr_data;
            end
            if (in_accept)
            begin
                sync_window_reg  <= sync_window_next;
                window_fill_reg  <= window_fill_next;
                phase_reg        <= phase_next;
                header_index_reg <= header_index_next;
                header_store_reg <= header_store_next;
                data_index_reg   <= data_index_next;
                first_byte_reg   <= first_byte_next;
                out_valid_reg    <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_data_reg  <= out_data_next;
            out_event_reg <= out_event_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_event_reg;

    `SPD_ASSERT(a_fill_range, window_fill_reg <= 3'd4, "window fill count out of range")
    `SPD_ASSERT(a_hdr_index_range, header_index_reg <= 3'd5, "header index out of range")
    `SPD_ASSERT(a_sync_to_header, (m_tvalid && (m_tuser == EV_SYNC)) |-> (phase_reg == PH_HEADER), "sync event without header capture")
    `SPD_ASSERT(a_accept_to_data, (m_tvalid && (m_tuser == EV_ACCEPT)) |-> ((phase_reg == PH_DATA) && (data_index_reg == 17'd0)), "accepted header without data phase")
    `SPD_ASSERT(a_class_on_end, (m_tvalid && (m_tdata[54:53] != CLASS_NONE)) |-> (m_tuser == EV_END), "classification outside packet end")

endmodule
